@@ rtl/mqrr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mqrr_pkg;

	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 64;

	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int NW        = $clog2(NUM_QUEUES + 1);
	localparam int AW        = QW + PW;
	localparam int MEM_DEPTH = 2 ** AW;

	localparam int QIDX_W   = 3;
	localparam int HANDLE_W = 16;
	localparam int CFG_W    = 4;
	localparam int STATUS_W = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

	typedef enum logic {
		OP_ENQ    = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		PUSH_OK   = 2'd0,
		PUSH_DROP = 2'd1,
		PUSH_NONE = 2'd2
	} push_status_t;

	typedef logic [QW-1:0] qid_t;
	typedef logic [PW-1:0] ptr_t;
	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic valid;
		qid_t queue;
	} grant_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [NW-1:0] eff_count(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return NW'(1);
		end
		if (int'(v) > NUM_QUEUES) begin
			return NW'(NUM_QUEUES);
		end
		return NW'(v);
	endfunction

endpackage

`default_nettype wire

@@ rtl/mqrr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mqrr_in_if import mqrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                op;
	logic [QIDX_W-1:0]   queue_index;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output op, output queue_index, output handle, input ready);
	modport sink (input valid, input op, input queue_index, input handle, output ready);
endinterface

interface mqrr_out_if import mqrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] push_status;
	logic                grant_valid;
	logic [QIDX_W-1:0]   grant_queue;
	logic [HANDLE_W-1:0] grant_handle;

	modport source (
		output valid, output push_status, output grant_valid, output grant_queue,
		output grant_handle, input ready
	);
	modport sink (
		input valid, input push_status, input grant_valid, input grant_queue,
		input grant_handle, output ready
	);
endinterface

`default_nettype wire

@@ rtl/mqrr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mqrr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/mqrr_arb.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mqrr_arb import mqrr_pkg::*; (
	input  logic [NUM_QUEUES-1:0] req,
	input  qid_t                  start,
	input  logic [NW-1:0]         count,
	output grant_t                grant
);

	logic [NUM_QUEUES-1:0] masked;
	logic [NUM_QUEUES-1:0] upper;
	logic [NUM_QUEUES-1:0] sel;

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			masked[i] = req[i] && (i < int'(count));
			upper[i]  = masked[i] && (i >= int'(start));
		end
		sel = (|upper) ? upper : masked;
	end

	always_comb begin
		grant = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (sel[i]) begin
				grant.valid = 1'b1;
				grant.queue = QW'(i);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/multi_queue_round_robin_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Round-robin scheduler over a set of circular handle queues.
// The item channel carries one beat per request: an enqueue (op, queue_index,
// handle) or a finish of the current service. The result channel returns one
// beat per item with the push status and, when the server was idle after the
// item, a grant of the next non-empty queue in rotation from the turn pointer.
// The queue count register is written through cfg_we/cfg_wdata while the
// block is idle; the user must keep to this, as the block does not enforce
// it. It resets to the full set of queues. An item is accepted in any cycle
// in which the pipeline register ahead of the output can move, so the
// sustained rate is one item per cycle while results are taken. All pointer,
// count and arbitration work is done in the accept cycle; the handle store is
// a synchronous memory whose registered read feeds the output register.
// Reset clears all queues, the turn pointer and the busy flag; no clearing
// pass is needed. When the receiver stalls, the result waits in the output
// register, one more item is taken into the stage behind it, and then the
// item channel deasserts ready until the result beat is taken.

module multi_queue_round_robin_scheduler import mqrr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	mqrr_in_if.sink          item,
	mqrr_out_if.source       result
);

	logic [CFG_W-1:0] nq_q;
	cnt_t             cnt_q  [NUM_QUEUES];
	ptr_t             head_q [NUM_QUEUES];
	ptr_t             tail_q [NUM_QUEUES];
	qid_t             turn_q;
	logic             busy_q;

	logic             s1_valid_q;
	push_status_t     push_s1;
	logic             gvalid_s1;
	qid_t             gq_s1;
	logic             fwd_s1;
	logic [HANDLE_W-1:0] handle_s1;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_push_q;
	logic                out_gvalid_q;
	logic [QIDX_W-1:0]   out_gq_q;
	logic [HANDLE_W-1:0] out_handle_q;

	logic [NW-1:0]         n;
	logic                  s1_move;
	logic                  acc;
	logic                  is_enq;
	qid_t                  qi;
	logic [NUM_QUEUES-1:0] full;
	logic [NUM_QUEUES-1:0] req;
	logic                  enq_ok;
	logic                  busy_pre;
	qid_t                  start;
	grant_t                gr;
	logic                  grant_ok;
	qid_t                  turn_nxt;
	logic                  fwd;
	cnt_t                  cnt_nxt [NUM_QUEUES];
	logic [HANDLE_W-1:0]   rdata;

	assign n       = eff_count(nq_q);
	assign s1_move = s1_valid_q && (!out_valid_q || result.ready);
	assign item.ready = !s1_valid_q || s1_move;
	assign acc     = item.valid && item.ready;
	assign is_enq  = (item.op == OP_ENQ);
	assign qi      = (int'(item.queue_index) < int'(n)) ? QW'(item.queue_index) : '0;

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			full[i] = (cnt_q[i] == CW'(QUEUE_DEPTH));
		end
	end

	assign enq_ok = is_enq && !full[qi];

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			req[i] = (cnt_q[i] != '0) || (enq_ok && (qi == QW'(i)));
		end
	end

	assign busy_pre = is_enq ? busy_q : 1'b0;
	assign start    = (int'(turn_q) < int'(n)) ? turn_q : '0;

	mqrr_arb u_arb (
		.req   (req),
		.start (start),
		.count (n),
		.grant (gr)
	);

	assign grant_ok = gr.valid && !busy_pre;
	assign turn_nxt = ((int'(gr.queue) + 1) == int'(n)) ? '0 : gr.queue + QW'(1);
	assign fwd      = (cnt_q[gr.queue] == '0);

	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			cnt_nxt[i] = cnt_q[i];
			if ((enq_ok && (qi == QW'(i))) && !(grant_ok && (gr.queue == QW'(i)))) begin
				cnt_nxt[i] = cnt_q[i] + CW'(1);
			end else if (!(enq_ok && (qi == QW'(i))) && (grant_ok && (gr.queue == QW'(i)))) begin
				cnt_nxt[i] = cnt_q[i] - CW'(1);
			end
		end
	end

	mqrr_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (acc && enq_ok),
		.waddr ({qi, tail_q[qi]}),
		.wdata (item.handle),
		.re    (acc && grant_ok),
		.raddr ({gr.queue, head_q[gr.queue]}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nq_q <= CFG_RESET;
		end else if (cfg_we) begin
			nq_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			turn_q <= '0;
			busy_q <= 1'b0;
		end else if (acc) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
			if (enq_ok) begin
				tail_q[qi] <= ptr_inc(tail_q[qi]);
			end
			if (grant_ok) begin
				head_q[gr.queue] <= ptr_inc(head_q[gr.queue]);
				turn_q           <= turn_nxt;
			end
			busy_q <= grant_ok ? 1'b1 : busy_pre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			push_s1   <= is_enq ? (enq_ok ? PUSH_OK : PUSH_DROP) : PUSH_NONE;
			gvalid_s1 <= grant_ok;
			gq_s1     <= grant_ok ? gr.queue : '0;
			fwd_s1    <= fwd;
			handle_s1 <= item.handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_push_q   <= push_s1;
			out_gvalid_q <= gvalid_s1;
			out_gq_q     <= QIDX_W'(gq_s1);
			out_handle_q <= !gvalid_s1 ? '0 : (fwd_s1 ? handle_s1 : rdata);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.push_status  = out_push_q;
	assign result.grant_valid  = out_gvalid_q;
	assign result.grant_queue  = out_gq_q;
	assign result.grant_handle = out_handle_q;

	a_busy_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(acc && (item.op == OP_FINISH)))
		else $error("server left busy without a finish beat");

	a_busy_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(acc && grant_ok))
		else $error("server became busy without a grant");

	a_turn_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(turn_q) |-> $past(acc && grant_ok))
		else $error("turn pointer moved without a grant");

endmodule

`default_nettype wire
